>>> src/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and fixed field widths for the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int FUNC_W    = 3;
	localparam int SEM_IDX_W = 8;
	localparam int INIT_W    = 16;
	localparam int CNT_OUT_W = 16;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC   = 3'd0,
		FUNC_DESTROY = 3'd1,
		FUNC_INIT    = 3'd2,
		FUNC_WAIT    = 3'd3,
		FUNC_POST    = 3'd4
	} func_t;

	typedef struct packed {
		func_t                   func;
		logic [SEM_IDX_W-1:0]    sem_index;
		logic [INIT_W-1:0]       init_count;
	} cmd_t;

	typedef struct packed {
		logic                    status;
		logic [SEM_IDX_W-1:0]    alloc_index;
		logic                    must_block;
		logic                    wake_one;
		logic                    wake_all;
		logic [CNT_OUT_W-1:0]    count_after;
	} res_t;

endpackage

>>> src/cst_find_free.sv
// ----------------------------------------------------------------------------
// cst_find_free
// Priority encoder: lowest-numbered free entry of the allocation flags.
// ----------------------------------------------------------------------------
module cst_find_free import cst_pkg::*; #(
	parameter int NUM_ENTRIES = 32,
	parameter int IDX_W       = 5
) (
	input  logic [NUM_ENTRIES-1:0] flags,
	output logic                   found,
	output logic [IDX_W-1:0]       index
);

	always_comb begin
		found = 1'b0;
		index = '0;
		for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
			if (!flags[i]) begin
				found = 1'b1;
				index = IDX_W'(i);
			end
		end
	end

endmodule

>>> src/counting_semaphore_table.sv
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores: alloc, destroy, init, wait and post commands.
// ----------------------------------------------------------------------------
// Path: a transaction passes the command register, then the result register,
// before result valid; the table updates at the same edge as the result.
// Throughput: one command per cycle while results are taken; lookup, free
// search and update fit in the single stage between the two registers.
// Reset: all entries free, both channels empty. Counts are not cleared by
// reset; an entry's count is zeroed when it is allocated.
// ----------------------------------------------------------------------------
module counting_semaphore_table import cst_pkg::*; #(
	parameter int NUM_SEMAPHORES = 32,
	parameter int COUNT_BITS     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [2:0] func, [10:3] sem_index, [26:11] init_count, [31:27] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [0] status, [8:1] alloc_index, [9] must_block, [10] wake_one,
	// [11] wake_all, [27:12] count_after, [31:28] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int IDX_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int EXT_W = ((COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W) + 1;
	localparam logic [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
	localparam logic [EXT_W-1:0] CMAX_EXT = {{(EXT_W-COUNT_BITS){1'b0}}, CMAX};
	localparam logic [EXT_W-1:0] CMIN_EXT = {{(EXT_W-COUNT_BITS){1'b1}}, CMIN};

	cmd_t                      cmd_in;
	cmd_t                      cmd_s1;
	logic                      valid_s1;
	logic                      advance;

	logic [NUM_SEMAPHORES-1:0] flags_q;
	logic [COUNT_BITS-1:0]     counts_q [NUM_SEMAPHORES];

	logic                      free_found;
	logic [IDX_W-1:0]          free_idx;

	logic [IDX_W-1:0]          sel;
	logic                      idx_ok;
	logic [COUNT_BITS-1:0]     cur;
	logic [EXT_W-1:0]          init_ext;
	logic [COUNT_BITS-1:0]     init_sat;

	logic                      wr_en;
	logic [IDX_W-1:0]          wr_idx;
	logic [COUNT_BITS-1:0]     wr_cnt;
	logic                      set_flag;
	logic                      clr_flag;
	logic                      report_cnt;
	logic [EXT_W-1:0]          wr_ext;
	res_t                      res_base;
	res_t                      res_d;
	res_t                      res_q;

	assign cmd_in.func       = func_t'(s_axis_tdata[2:0]);
	assign cmd_in.sem_index  = s_axis_tdata[10:3];
	assign cmd_in.init_count = s_axis_tdata[26:11];

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1 <= cmd_in;
		end
	end

	cst_find_free #(
		.NUM_ENTRIES (NUM_SEMAPHORES),
		.IDX_W       (IDX_W)
	) u_find_free (
		.flags (flags_q),
		.found (free_found),
		.index (free_idx)
	);

	assign sel    = cmd_s1.sem_index[IDX_W-1:0];
	assign idx_ok = ({1'b0, cmd_s1.sem_index} < (SEM_IDX_W+1)'(NUM_SEMAPHORES)) && flags_q[sel];
	assign cur    = counts_q[sel];

	assign init_ext = {{(EXT_W-INIT_W){cmd_s1.init_count[INIT_W-1]}}, cmd_s1.init_count};

	always_comb begin
		if ($signed(init_ext) > $signed(CMAX_EXT)) begin
			init_sat = CMAX;
		end else if ($signed(init_ext) < $signed(CMIN_EXT)) begin
			init_sat = CMIN;
		end else begin
			init_sat = init_ext[COUNT_BITS-1:0];
		end
	end

	always_comb begin
		res_base        = '0;
		res_base.status = 1'b1;
		wr_en           = 1'b0;
		wr_idx          = sel;
		wr_cnt          = cur;
		set_flag        = 1'b0;
		clr_flag        = 1'b0;
		report_cnt      = 1'b0;
		case (cmd_s1.func)
			FUNC_ALLOC: begin
				if (free_found) begin
					res_base.status      = 1'b0;
					res_base.alloc_index = SEM_IDX_W'(free_idx);
					wr_en                = 1'b1;
					wr_idx               = free_idx;
					wr_cnt               = '0;
					set_flag             = 1'b1;
				end
			end
			FUNC_DESTROY: begin
				if (idx_ok) begin
					res_base.status   = 1'b0;
					res_base.wake_all = cur[COUNT_BITS-1];
					wr_en             = 1'b1;
					wr_cnt            = '0;
					clr_flag          = 1'b1;
				end
			end
			FUNC_INIT: begin
				if (idx_ok) begin
					res_base.status = 1'b0;
					wr_en           = 1'b1;
					wr_cnt          = init_sat;
					report_cnt      = 1'b1;
				end
			end
			FUNC_WAIT: begin
				if (idx_ok) begin
					res_base.status = 1'b0;
					wr_en           = 1'b1;
					wr_cnt          = (cur == CMIN) ? CMIN : cur - 1'b1;
					report_cnt      = 1'b1;
				end
			end
			FUNC_POST: begin
				if (idx_ok) begin
					res_base.status   = 1'b0;
					res_base.wake_one = cur[COUNT_BITS-1];
					wr_en             = 1'b1;
					wr_cnt            = (cur == CMAX) ? CMAX : cur + 1'b1;
					report_cnt        = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr_ext = {{(EXT_W-COUNT_BITS){wr_cnt[COUNT_BITS-1]}}, wr_cnt};

	always_comb begin
		res_d = res_base;
		if (report_cnt) begin
			res_d.count_after = wr_ext[CNT_OUT_W-1:0];
			res_d.must_block  = (cmd_s1.func == FUNC_WAIT) && wr_cnt[COUNT_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (advance) begin
			if (set_flag) begin
				flags_q[wr_idx] <= 1'b1;
			end
			if (clr_flag) begin
				flags_q[wr_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			counts_q[wr_idx] <= wr_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tdata = {
		{(OUT_DATA_W-28){1'b0}},
		res_q.count_after,
		res_q.wake_all,
		res_q.wake_one,
		res_q.must_block,
		res_q.alloc_index,
		res_q.status
	};

	a_alloc_status: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1.func == FUNC_ALLOC
		|=> m_axis_tvalid && (res_q.status == !$past(free_found)))
		else $error("alloc status does not match free search");

	a_destroy_frees: assert property (@(posedge clk) disable iff (!arst_n)
		advance && clr_flag |=> !flags_q[$past(wr_idx)])
		else $error("destroyed entry still marked allocated");

	a_alloc_claims: assert property (@(posedge clk) disable iff (!arst_n)
		advance && set_flag |=> flags_q[$past(wr_idx)] && counts_q[$past(wr_idx)] == '0)
		else $error("allocated entry not claimed with zero count");

	a_block_negative: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_q.must_block |-> res_q.count_after[CNT_OUT_W-1] && !res_q.status)
		else $error("must_block with non-negative count");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1))
		else $error("stalled command overwritten");

endmodule

>>> verif/cst_result_checker.sv
// ----------------------------------------------------------------------------
// cst_result_checker
// Watches both stream channels of the counting semaphore table. Every command
// transaction is run through a local model of the table, and each result
// transaction is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module cst_result_checker import cst_pkg::*; #(
	parameter int NUM_SEMAPHORES = 32,
	parameter int COUNT_BITS     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    pending,
	output int                    errors
);

	localparam int CNT_MAX = (1 << (COUNT_BITS - 1)) - 1;
	localparam int CNT_MIN = -CNT_MAX - 1;

	bit   sem_in_use [NUM_SEMAPHORES];
	int   sem_count  [NUM_SEMAPHORES];
	res_t due_results [$];
	int   fail_count = 0;

	assign errors = fail_count;

	task automatic report_mismatch(input string msg);
		if (fail_count < 40) begin
			$display("%0t: %s", $time, msg);
		end
		fail_count++;
	endtask

	function automatic int clamp_count(input int v);
		if (v > CNT_MAX) begin
			return CNT_MAX;
		end
		if (v < CNT_MIN) begin
			return CNT_MIN;
		end
		return v;
	endfunction

	function automatic res_t apply_command(input logic [FUNC_W-1:0] op,
			input logic [SEM_IDX_W-1:0] idx, input logic [INIT_W-1:0] raw);
		res_t r;
		int   c;
		r = '0;
		r.status = 1'b1;
		if (op == FUNC_ALLOC) begin
			for (int i = 0; i < NUM_SEMAPHORES; i++) begin
				if (!sem_in_use[i]) begin
					sem_in_use[i] = 1'b1;
					r.status = 1'b0;
					r.alloc_index = SEM_IDX_W'(i);
					r.count_after = CNT_OUT_W'(sem_count[i]);
					break;
				end
			end
		end else if (op <= FUNC_POST && idx < NUM_SEMAPHORES && sem_in_use[idx]) begin
			c = sem_count[idx];
			r.status = 1'b0;
			case (op)
				FUNC_DESTROY: begin
					r.wake_all = (c < 0);
					sem_in_use[idx] = 1'b0;
					c = 0;
				end
				FUNC_INIT: begin
					c = clamp_count($signed(raw));
				end
				FUNC_WAIT: begin
					c = clamp_count(c - 1);
					r.must_block = (c < 0);
				end
				default: begin
					r.wake_one = (c < 0);
					c = clamp_count(c + 1);
				end
			endcase
			sem_count[idx] = c;
			r.count_after = CNT_OUT_W'(c);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEMAPHORES; i++) begin
				sem_in_use[i] = 1'b0;
				sem_count[i] = 0;
			end
			due_results.delete();
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				due_results.push_back(apply_command(s_axis_tdata[2:0],
					s_axis_tdata[10:3], s_axis_tdata[26:11]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.status      = m_axis_tdata[0];
				got.alloc_index = m_axis_tdata[8:1];
				got.must_block  = m_axis_tdata[9];
				got.wake_one    = m_axis_tdata[10];
				got.wake_all    = m_axis_tdata[11];
				got.count_after = m_axis_tdata[27:12];
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result transaction %h",
						m_axis_tdata));
				end else begin
					want = due_results.pop_front();
					if (got.status !== want.status)
						report_mismatch($sformatf("status: got %0d expected %0d",
							got.status, want.status));
					if (got.alloc_index !== want.alloc_index)
						report_mismatch($sformatf("alloc_index: got %0d expected %0d",
							got.alloc_index, want.alloc_index));
					if (got.must_block !== want.must_block)
						report_mismatch($sformatf("must_block: got %0d expected %0d",
							got.must_block, want.must_block));
					if (got.wake_one !== want.wake_one)
						report_mismatch($sformatf("wake_one: got %0d expected %0d",
							got.wake_one, want.wake_one));
					if (got.wake_all !== want.wake_all)
						report_mismatch($sformatf("wake_all: got %0d expected %0d",
							got.wake_all, want.wake_all));
					if (got.count_after !== want.count_after)
						report_mismatch($sformatf("count_after: got %h expected %h",
							got.count_after, want.count_after));
				end
			end
			pending <= due_results.size();
		end
	end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives command transactions into the counting semaphore table: a directed
// pass over error cases, saturation and wakeups, then random commands in
// fill and drain stretches under varying sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import cst_pkg::*;

	localparam int NUM_SEM         = 32;
	localparam int ITEMS_PER_PHASE = 440;
	localparam int HOLD_CYCLES     = 400;
	localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_LO  = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_MID = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_HI  = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int pending;
	int errors;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_req     = 0;
	int hold_seen;
	int hold_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	counting_semaphore_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	cst_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.pending       (pending),
		.errors        (errors)
	);

	// result receiver: random stalls, plus a long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("counting_semaphore_table test failed");
		$finish;
	end

	task automatic send_cmd(input logic [FUNC_W-1:0] op, input logic [SEM_IDX_W-1:0] idx,
			input logic [INIT_W-1:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W - FUNC_W - SEM_IDX_W - INIT_W){1'b0}}, val, idx, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_random(input int alloc_w, input int destroy_w);
		int                   roll;
		logic [FUNC_W-1:0]    op;
		logic [SEM_IDX_W-1:0] idx;
		logic [INIT_W-1:0]    val;
		roll = $urandom_range(99);
		if (roll < alloc_w) begin
			op = FUNC_ALLOC;
		end else if (roll < alloc_w + destroy_w) begin
			op = FUNC_DESTROY;
		end else if (roll < 97) begin
			roll = $urandom_range(9);
			op = (roll < 2) ? FUNC_INIT : (roll < 6) ? FUNC_WAIT : FUNC_POST;
		end else begin
			op = FUNC_W'($urandom_range(FUNC_UNKNOWN_LO, FUNC_UNKNOWN_HI));
		end
		roll = $urandom_range(99);
		if (roll < 70) begin
			idx = SEM_IDX_W'($urandom_range(7));
		end else if (roll < 92) begin
			idx = SEM_IDX_W'($urandom_range(NUM_SEM - 1));
		end else begin
			idx = SEM_IDX_W'($urandom_range(255));
		end
		case ($urandom_range(7))
			0: val = 16'h7fff;
			1: val = 16'h8000;
			2: val = 16'h7ffe;
			3: val = 16'h8001;
			4: val = INIT_W'($urandom_range(6) - 3);
			default: val = INIT_W'($urandom);
		endcase
		send_cmd(op, idx, val);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// commands on a free entry and unknown operations
		send_cmd(FUNC_WAIT, 8'd0, 16'h0000);
		send_cmd(FUNC_INIT, 8'd0, 16'h1234);
		send_cmd(FUNC_POST, 8'd0, 16'h0000);
		send_cmd(FUNC_DESTROY, 8'd0, 16'h0000);
		send_cmd(FUNC_UNKNOWN_LO, 8'd0, 16'hffff);
		send_cmd(FUNC_UNKNOWN_MID, 8'd0, 16'h0000);
		send_cmd(FUNC_UNKNOWN_HI, 8'hff, 16'hffff);
		// alloc ignores index and count fields
		send_cmd(FUNC_ALLOC, 8'hff, 16'hffff);
		// saturation at both ends, block and wake
		send_cmd(FUNC_INIT, 8'd0, 16'h7fff);
		send_cmd(FUNC_POST, 8'd0, 16'h0000);
		send_cmd(FUNC_WAIT, 8'd0, 16'h0000);
		send_cmd(FUNC_INIT, 8'd0, 16'h8000);
		send_cmd(FUNC_WAIT, 8'd0, 16'h0000);
		send_cmd(FUNC_POST, 8'd0, 16'h0000);
		// index out of range
		send_cmd(FUNC_WAIT, 8'd32, 16'h0000);
		send_cmd(FUNC_POST, 8'hff, 16'h0000);
		// destroy with waiters, then on a freed entry
		send_cmd(FUNC_INIT, 8'd0, 16'hffff);
		send_cmd(FUNC_WAIT, 8'd0, 16'h0000);
		send_cmd(FUNC_DESTROY, 8'd0, 16'h0000);
		send_cmd(FUNC_DESTROY, 8'd0, 16'h0000);
		// reuse of a freed entry comes back with count zero
		send_cmd(FUNC_ALLOC, 8'd0, 16'h0000);
		send_cmd(FUNC_ALLOC, 8'd0, 16'h0000);
		send_cmd(FUNC_DESTROY, 8'd1, 16'h0000);
		send_cmd(FUNC_INIT, 8'd0, 16'h0000);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
				default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 0 && n == 100) begin
					hold_req++;
				end
				// alternate fill stretches (table runs full) with drain stretches
				if ((n / 110) % 2 == 0) begin
					send_random(35, 3);
				end else begin
					send_random(6, 30);
				end
			end
			if (ph == 1) begin
				s_axis_tvalid <= 1'b0;
				// pending is registered and lags the last accepted transaction
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("counting_semaphore_table test passed");
		end else begin
			$display("counting_semaphore_table test failed");
		end
		$finish;
	end

endmodule
